/* sv/smm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the square matrix multiply core.
// No dependencies; imported by the core and its checker.
package smm_pkg;

   // Field widths
   localparam int VALUE_W = 16;   // signed Q8.8 elements of A and B
   localparam int PROD_W  = 32;   // exact Q16.16 product
   localparam int C_W     = 35;   // product element, 16 fraction bits
   localparam int CSR_W   = 4;    // matrix_size register

   // Defaults
   localparam int MAX_N_DEFAULT = 8;
   localparam logic [CSR_W-1:0] SIZE_RESET = 4'd8;

endpackage

/* sv/square_matrix_multiply_core.sv */
`timescale 1ns / 1ps
// Square matrix multiply core: C = A x B, row-major, one shared MAC unit.
// Operation: each accepted transaction loads one pair; the final one starts N*N*N
// MAC steps through the shared multiplier (operand read, product and output
// registers), and each element of C is output after its N steps; an output stall holds the pipeline.
// Loading: no new pair is taken until the product has drained, as the single MAC is busy.
// Reset: synchronous; clears the load count, sequencer and size (to 8).
// The A and B stores are not cleared; there is no clearing pass.
module square_matrix_multiply_core
   import smm_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [CSR_W-1:0]          csr_wr_data,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_a_value,
   input  logic signed [VALUE_W-1:0] req_b_value,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [C_W-1:0]     rsp_c_value,
   output logic                      rsp_last
);

   localparam int DEPTH = MAX_N * MAX_N;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NW    = $clog2(MAX_N + 1);
   localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int TW    = 2 * NW;
   localparam int LW    = (CW > TW) ? CW : TW;
   localparam logic [CSR_W:0] MAX_N_C = (CSR_W + 1)'(MAX_N);
   localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // flags that travel with each MAC step
   typedef struct packed {
      logic first;   // first k of an element
      logic lastk;   // last k of an element
      logic lastc;   // belongs to the final element of C
   } step_type;

   // storage
   logic [VALUE_W-1:0] a_mem [DEPTH];
   logic [VALUE_W-1:0] b_mem [DEPTH];

   // control registers
   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     size_ff, size_in;
   logic [CW-1:0]        load_count_ff, load_count_in;
   logic [AW-1:0]        n_step_ff, n_step_in;
   logic [IW-1:0]        nm1_ff, nm1_in;
   logic [IW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0]        a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [AW-1:0]        row_base_ff, row_base_in;

   // pipeline registers
   logic                      s1_valid_ff, s1_valid_in;
   step_type                  s1_step_ff, s1_step_in;
   logic signed [VALUE_W-1:0] a_rd_ff, b_rd_ff;
   logic                      s2_valid_ff, s2_valid_in;
   step_type                  s2_step_ff, s2_step_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [C_W-1:0]     acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [C_W-1:0]     rsp_c_ff, rsp_c_in;
   logic                      rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic [CSR_W:0]        size_sat;
   logic [NW-1:0]         n_use;
   logic [TW-1:0]         total;
   logic [CW-1:0]         count_next;
   logic                  accept;
   logic                  mem_wr;
   logic                  adv;
   logic                  issue;
   logic signed [C_W-1:0] sum;

   // clamp the configured size into 1..MAX_N
   always_comb begin
      if (size_ff == '0) begin
         size_sat = (CSR_W + 1)'(1);
      end else if ({1'b0, size_ff} > MAX_N_C) begin
         size_sat = MAX_N_C;
      end else begin
         size_sat = {1'b0, size_ff};
      end
      n_use = NW'(size_sat);
      total = TW'(n_use) * TW'(n_use);
   end

   assign accept     = req_valid && !req_stall;
   assign mem_wr     = accept && (load_count_ff < DEPTH_C);
   assign count_next = mem_wr ? load_count_ff + CW'(1) : load_count_ff;
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign issue      = (state_ff == ST_RUN) && adv;
   assign sum        = (s2_step_ff.first ? '0 : acc_ff) + C_W'(prod_ff);

   // next-state logic: loader, MAC sequencer and pipeline
   always_comb begin
      state_in      = state_ff;
      size_in       = csr_wr_en ? csr_wr_data : size_ff;
      load_count_in = load_count_ff;
      n_step_in     = n_step_ff;
      nm1_in        = nm1_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      a_addr_in     = a_addr_ff;
      b_addr_in     = b_addr_ff;
      row_base_in   = row_base_ff;
      s1_valid_in   = s1_valid_ff;
      s1_step_in    = s1_step_ff;
      s2_valid_in   = s2_valid_ff;
      s2_step_in    = s2_step_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_c_in      = rsp_c_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // start the product once all pairs are in
               if (LW'(count_next) >= LW'(total)) begin
                  state_in      = ST_RUN;
                  load_count_in = '0;
                  n_step_in     = AW'(n_use);
                  nm1_in        = IW'(n_use - NW'(1));
                  i_in          = '0;
                  j_in          = '0;
                  k_in          = '0;
                  a_addr_in     = '0;
                  b_addr_in     = '0;
                  row_base_in   = '0;
               end else begin
                  load_count_in = count_next;
               end
            end
         end
         ST_RUN: begin
            // walk i, j, k; A address steps by one, B address by N
            if (issue) begin
               if (k_ff == nm1_ff) begin
                  k_in = '0;
                  if (j_ff == nm1_ff) begin
                     j_in        = '0;
                     i_in        = i_ff + IW'(1);
                     row_base_in = row_base_ff + n_step_ff;
                     a_addr_in   = row_base_ff + n_step_ff;
                     b_addr_in   = '0;
                     if (i_ff == nm1_ff) begin
                        state_in = ST_DRAIN;
                     end
                  end else begin
                     j_in      = j_ff + IW'(1);
                     a_addr_in = row_base_ff;
                     b_addr_in = AW'(j_ff) + AW'(1);
                  end
               end else begin
                  k_in      = k_ff + IW'(1);
                  a_addr_in = a_addr_ff + AW'(1);
                  b_addr_in = b_addr_ff + n_step_ff;
               end
            end
         end
         ST_DRAIN: begin
            // wait for the pipeline and output register to empty
            if (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance the MAC pipeline as one unit; hold it on output stall
      if (adv) begin
         s1_valid_in      = issue;
         s1_step_in.first = (k_ff == '0);
         s1_step_in.lastk = (k_ff == nm1_ff);
         s1_step_in.lastc = (i_ff == nm1_ff) && (j_ff == nm1_ff);
         s2_valid_in      = s1_valid_ff;
         s2_step_in       = s1_step_ff;
         prod_in          = PROD_W'(a_rd_ff) * PROD_W'(b_rd_ff);
         rsp_valid_in     = s2_valid_ff && s2_step_ff.lastk;
         rsp_c_in         = sum;
         rsp_last_in      = s2_step_ff.lastc;
         if (s2_valid_ff) begin
            acc_in = sum;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= SIZE_RESET;
         load_count_ff <= '0;
         n_step_ff     <= '0;
         nm1_ff        <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         a_addr_ff     <= '0;
         b_addr_ff     <= '0;
         row_base_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s1_step_ff    <= '0;
         s2_valid_ff   <= 1'b0;
         s2_step_ff    <= '0;
         prod_ff       <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_c_ff      <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         load_count_ff <= load_count_in;
         n_step_ff     <= n_step_in;
         nm1_ff        <= nm1_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         a_addr_ff     <= a_addr_in;
         b_addr_ff     <= b_addr_in;
         row_base_ff   <= row_base_in;
         s1_valid_ff   <= s1_valid_in;
         s1_step_ff    <= s1_step_in;
         s2_valid_ff   <= s2_valid_in;
         s2_step_ff    <= s2_step_in;
         prod_ff       <= prod_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_c_ff      <= rsp_c_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // A and B stores: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         a_mem[load_count_ff[AW-1:0]] <= req_a_value;
         b_mem[load_count_ff[AW-1:0]] <= req_b_value;
      end
      if (adv) begin
         a_rd_ff <= a_mem[a_addr_ff];
         b_rd_ff <= b_mem[b_addr_ff];
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_c_value = rsp_c_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* sv/smm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the square matrix multiply core, bound into the core module.
// Depends on smm_pkg for field widths.
module smm_checker
   import smm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic signed [C_W-1:0] rsp_c_value,
   input logic                  rsp_last
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_c_value) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   // a stalled input transaction stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled input transaction dropped");

   // no load is taken while a result is pending
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input ready while a result is pending");

   // a result only follows a busy cycle
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a compute phase");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind square_matrix_multiply_core smm_checker u_smm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_c_value (rsp_c_value),
   .rsp_last    (rsp_last)
);

/* tb/sv/smm_product_checker.sv */
`timescale 1ns / 1ps
// Product checker for the square matrix multiply core: predicts every C element.
// Depends on smm_pkg; watches the csr_, req_ and rsp_ ports, never drives them.
module smm_product_checker
   import smm_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_W-1:0]          csr_wr_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_a_value,
   input  logic signed [VALUE_W-1:0] req_b_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [C_W-1:0]     rsp_c_value,
   input  logic                      rsp_last,
   output int                        mismatch_count,
   output int                        due_count,
   output int                        elements_checked,
   output int                        products_checked
);

   localparam int DEPTH = MAX_N * MAX_N;

   typedef struct {
      logic signed [C_W-1:0] c_value;
      logic                  last;
   } c_element_type;

   // Shadow of the block: both operand stores, load count and size register
   logic signed [VALUE_W-1:0] a_mem [DEPTH];
   logic signed [VALUE_W-1:0] b_mem [DEPTH];
   int unsigned               pairs_held;
   logic [CSR_W-1:0]          size_code;
   c_element_type             c_elements_due [$];

   int            bad_tally = 0;
   int            element_tally = 0;
   int            product_tally = 0;
   c_element_type want;

   // Zero reads as one, anything above MAX_N saturates
   function automatic int unsigned size_in_force(logic [CSR_W-1:0] code);
      int unsigned n;
      n = code;
      if (n == 0) n = 1;
      if (n > MAX_N) n = MAX_N;
      return n;
   endfunction

   // Store one pair; once N*N are held, queue the whole product row-major
   task automatic load_pair_and_multiply(input logic signed [VALUE_W-1:0] a,
                                         input logic signed [VALUE_W-1:0] b);
      int unsigned   n;
      int unsigned   i;
      int unsigned   j;
      int unsigned   k;
      longint        acc;
      c_element_type e;
      n = size_in_force(size_code);
      if (pairs_held < DEPTH) begin
         a_mem[pairs_held] = a;
         b_mem[pairs_held] = b;
         pairs_held++;
      end
      if (pairs_held >= n * n) begin
         for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
               acc = 0;
               for (k = 0; k < n; k++) begin
                  acc += longint'(a_mem[i * n + k]) * longint'(b_mem[k * n + j]);
               end
               e.c_value = acc[C_W-1:0];
               e.last    = (i == n - 1) && (j == n - 1);
               c_elements_due.insert(c_elements_due.size(), e);
            end
         end
         pairs_held = 0;
      end
   endtask

   // Track config, predict on each accepted pair, compare each accepted result
   always @(posedge clock) begin
      if (reset) begin
         pairs_held = 0;
         size_code  = SIZE_RESET;
      end else begin
         if (csr_wr_en) size_code = csr_wr_data;
         if (req_valid && !req_stall) load_pair_and_multiply(req_a_value, req_b_value);
         if (rsp_valid && !rsp_stall) begin
            if (c_elements_due.size() == 0) begin
               $display("%0t: result with nothing due: c_value %0d last %0b",
                        $time, rsp_c_value, rsp_last);
               bad_tally++;
            end else begin
               want = c_elements_due.pop_front();
               if (rsp_c_value !== want.c_value) begin
                  $display("%0t: c_value mismatch: expected %0d, actual %0d",
                           $time, want.c_value, rsp_c_value);
                  bad_tally++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last);
                  bad_tally++;
               end
               element_tally++;
               if (want.last) product_tally++;
            end
         end
      end
      mismatch_count   <= bad_tally;
      due_count        <= c_elements_due.size();
      elements_checked <= element_tally;
      products_checked <= product_tally;
   end

endmodule

/* tb/sv/square_matrix_multiply_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for square_matrix_multiply_core: clock, reset, stimulus, verdict.
// Depends on smm_pkg, the core and smm_product_checker, which checks every product.
module square_matrix_multiply_core_tb;
   import smm_pkg::*;

   localparam int MAX_N         = MAX_N_DEFAULT;
   localparam int PAIR_TARGET   = 320;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = MAX_N * MAX_N * MAX_N + 64;
   localparam int MAX_WAIT      = 12;

   localparam logic signed [VALUE_W-1:0] MOST_NEG = 16'sh8000;
   localparam logic signed [VALUE_W-1:0] MOST_POS = 16'sh7FFF;
   localparam logic signed [VALUE_W-1:0] MINUS_ONE = -16'sd1;
   localparam logic signed [VALUE_W-1:0] PLUS_ONE = 16'sd1;
   localparam logic signed [VALUE_W-1:0] ZERO_VAL = 16'sd0;

   typedef enum {FILL_RANDOM, FILL_EXTREMES, FILL_MOST_NEG, FILL_MOST_POS} fill_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_W-1:0]          csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_a_value = '0;
   logic signed [VALUE_W-1:0] req_b_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [C_W-1:0]     rsp_c_value;
   logic                      rsp_last;

   int mismatch_count;
   int due_count;
   int elements_checked;
   int products_checked;

   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int          pairs_sent = 0;
   int          size_writes = 0;
   int unsigned n_now;
   int          quiet_cycles = 0;
   int          hold_left = 0;
   int          phase;
   int          pick;
   int          products;
   logic [CSR_W-1:0] code;
   logic [15:0]      codes_seen = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   square_matrix_multiply_core #(.MAX_N(MAX_N)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_c_value (rsp_c_value),
      .rsp_last    (rsp_last)
   );

   smm_product_checker #(.MAX_N(MAX_N)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_a_value      (req_a_value),
      .req_b_value      (req_b_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_c_value      (rsp_c_value),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .due_count        (due_count),
      .elements_checked (elements_checked),
      .products_checked (products_checked)
   );

   // Result side: after each accepted result, stall for a random wait (none when rx_quiet)
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_stall <= (hold_left != 0);
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= (hold_left != 0);
      end
   end

   // Watchdog: end the run after too long without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value(fill_style_type style);
      logic signed [VALUE_W-1:0] v;
      v = VALUE_W'($urandom_range(0, 65535));
      case (style)
         FILL_MOST_NEG: v = MOST_NEG;
         FILL_MOST_POS: v = MOST_POS;
         FILL_EXTREMES: begin
            case ($urandom_range(0, 5))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = ZERO_VAL;
               3: v = MINUS_ONE;
               4: v = PLUS_ONE;
               default: ;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   // Offer one pair after a random gap; valid stays high on return
   task automatic send_pair(input logic signed [VALUE_W-1:0] a,
                            input logic signed [VALUE_W-1:0] b);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic send_matrix(input int unsigned n, input fill_style_type style);
      repeat (n * n) send_pair(pick_value(style), pick_value(style));
   endtask

   // Drop valid, hold until nothing is due and the core has settled
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_now = (value == 0) ? 1 : ((value > MAX_N) ? MAX_N : value);
      codes_seen[value] = 1'b1;
      size_writes++;
   endtask

   task automatic send_extremes(input int count);
      repeat (count) send_pair(pick_value(FILL_EXTREMES), pick_value(FILL_EXTREMES));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Size from reset, all most-negative: the largest positive element
      send_matrix(SIZE_RESET, FILL_MOST_NEG);

      // One by one: extreme products
      write_size(4'd1);
      send_pair(MOST_NEG, MOST_NEG);
      send_pair(MOST_POS, MOST_POS);
      send_pair(MOST_NEG, MOST_POS);
      send_pair(ZERO_VAL, MINUS_ONE);
      // Size zero runs as one by one
      write_size(4'd0);
      send_pair(MINUS_ONE, MINUS_ONE);
      send_pair(PLUS_ONE, MOST_NEG);
      // Two by two with mixed extremes
      write_size(4'd2);
      send_pair(MOST_POS, MOST_NEG);
      send_pair(MOST_NEG, MOST_NEG);
      send_pair(MINUS_ONE, MOST_POS);
      send_pair(PLUS_ONE, PLUS_ONE);
      // Size lowered mid-load: the next pair fires the smaller product
      write_size(4'd3);
      send_extremes(5);
      write_size(4'd2);
      send_extremes(1);
      // Size raised mid-load: loading carries on to the larger count
      send_extremes(2);
      write_size(4'd3);
      send_extremes(7);

      // Random phases: mostly small sizes, whole products, some partial loads
      phase = 0;
      while (pairs_sent < PAIR_TARGET) begin
         pick = $urandom_range(0, 9);
         if (phase == 0) code = 4'd15;
         else if (pick < 6) code = CSR_W'($urandom_range(1, 4));
         else if (pick < 8) code = CSR_W'($urandom_range(0, 15));
         else code = CSR_W'($urandom_range(5, 8));
         write_size(code);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         products = (n_now >= 6) ? 1 : $urandom_range(1, 3);
         repeat (products) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) send_matrix(n_now, FILL_RANDOM);
            else if (pick < 8) send_matrix(n_now, FILL_EXTREMES);
            else if (pick == 8) send_matrix(n_now, FILL_MOST_NEG);
            else send_matrix(n_now, FILL_MOST_POS);
         end
         if (n_now > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, n_now * n_now - 1))
               send_pair(pick_value(FILL_RANDOM), pick_value(FILL_RANDOM));
         end
         phase++;
      end

      // Drain: wait out everything due, then the core's longest latency
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Loaded %0d pairs over %0d size writes (codes used %b); checked %0d elements",
               pairs_sent, size_writes, codes_seen, elements_checked);
      $display("in %0d products, %0d mismatches", products_checked, mismatch_count);
      if (mismatch_count == 0 && due_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* square_matrix_multiply_core.f */
sv/smm_pkg.sv
sv/square_matrix_multiply_core.sv
sv/smm_checker.sv
tb/sv/smm_product_checker.sv
tb/sv/square_matrix_multiply_core_tb.sv
